[hw/rtl/wrsd_pkg.sv]
package wrsd_pkg;

    // Window depth, a power of two so that the mean is a plain shift.
    localparam int WINDOW_DEPTH = 256;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 2 * SAMPLE_W - 1;   // (-32768)^2 = 2^30 fits in 31 bits
    localparam int SUM_W    = SQ_W + PTR_W;
    localparam int ROOT_W   = 16;
    localparam int RAD_W    = 2 * ROOT_W;

    localparam logic MODE_STORE = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Request to the sample store: one shared address for read and write.
    typedef struct packed {
        logic                       clr;
        logic                       wr_en;
        logic [PTR_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0] wr_data;
    } store_req_t;

endpackage

[hw/rtl/windowed_rms_sound_detector.sv]
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid / in_stall  mode, sample
// out      output     out_valid / out_stall level, sound_detected, window_full, samples_taken
// cfg      input      cfg_we (no wait)     cfg_wdata -> detect_threshold
//
// A store beat passes the squarer states, the root launch and the root steps
// before its result sits in the output register; a clear beat skips the squarer.
// The cost is set by the square root: one shared 16-step bit-serial root unit, plus
// the one shared squarer (old entry out, new entry in) with the store's registered read.
// Reset clears pointer, sum, ready flag, count, threshold and every store
// valid bit at once, so the block accepts a beat in the first cycle after.
// in_stall is high whenever a beat is in work. A waiting result does not
// block the input; only a finished root waits for the output register.
module windowed_rms_sound_detector
    import wrsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_we,
    input  logic [15:0]                cfg_wdata,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic signed [SAMPLE_W-1:0] sample,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ROOT_W-1:0]          level,
    output logic                       sound_detected,
    output logic                       window_full,
    output logic [31:0]                samples_taken
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_OLD,    // square the entry being overwritten
        ST_SQ_NEW,    // subtract old square, square the new sample
        ST_ACC,       // add new square, advance pointer and count
        ST_START,     // launch the root on the mean square
        ST_ROOT,      // root unit stepping
        ST_FINISH     // hand the result to the output register
    } state_t;

    state_t                     state_reg;
    logic [PTR_W-1:0]           ptr_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic                       ready_reg;
    logic [31:0]                count_reg;
    logic [15:0]                thr_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [SQ_W-1:0]            prod_reg;

    logic                       out_valid_reg;
    logic [ROOT_W-1:0]          level_reg;
    logic                       detected_reg;
    logic                       full_reg;
    logic [31:0]                taken_reg;

    logic                       accept;
    logic                       out_free;
    logic [PTR_W-1:0]           ptr_next;
    logic                       ptr_wrap;

    store_req_t                 store_req;
    logic signed [SAMPLE_W-1:0] old_data;
    logic                       old_valid;
    logic signed [SAMPLE_W-1:0] old_sample;

    logic signed [SAMPLE_W-1:0] mul_op;
    logic signed [2*SAMPLE_W-1:0] mul_full;

    logic                       root_start;
    logic                       root_busy;
    logic [ROOT_W-1:0]          root_val;
    logic [RAD_W-1:0]           mean_sq;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign ptr_wrap = (ptr_reg == PTR_W'(WINDOW_DEPTH - 1));
    assign ptr_next = ptr_wrap ? '0 : (ptr_reg + 1'b1);

    // Store: read under the pointer at acceptance, overwrite in the next cycle.
    always_comb
    begin
        store_req.clr     = accept && (mode == MODE_CLEAR);
        store_req.wr_en   = (state_reg == ST_SQ_OLD);
        store_req.addr    = ptr_reg;
        store_req.wr_data = sample_reg;
    end

    wrsd_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (store_req),
        .rd_data  (old_data),
        .rd_valid (old_valid)
    );

    assign old_sample = old_valid ? old_data : '0;

    // Shared squarer; the product is registered before it meets the sum.
    assign mul_op   = (state_reg == ST_SQ_OLD) ? old_sample : sample_reg;
    assign mul_full = mul_op * mul_op;

    // Depth is a power of two: the floor of the mean is a shift.
    assign mean_sq    = RAD_W'(sum_reg[SUM_W-1:PTR_W]);
    assign root_start = (state_reg == ST_START);

    wrsd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (mean_sq),
        .busy     (root_busy),
        .root     (root_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            ready_reg     <= 1'b0;
            count_reg     <= '0;
            thr_reg       <= '0;
            sample_reg    <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            detected_reg  <= 1'b0;
            full_reg      <= 1'b0;
            taken_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sample_reg <= sample;
                        if (mode == MODE_CLEAR)
                        begin
                            ptr_reg   <= '0;
                            sum_reg   <= '0;
                            ready_reg <= 1'b0;
                            state_reg <= ST_START;
                        end
                        else
                        begin
                            state_reg <= ST_SQ_OLD;
                        end
                    end
                end
                ST_SQ_OLD:
                begin
                    prod_reg  <= mul_full[SQ_W-1:0];
                    state_reg <= ST_SQ_NEW;
                end
                ST_SQ_NEW:
                begin
                    sum_reg   <= sum_reg - SUM_W'(prod_reg);
                    prod_reg  <= mul_full[SQ_W-1:0];
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    sum_reg   <= sum_reg + SUM_W'(prod_reg);
                    ptr_reg   <= ptr_next;
                    count_reg <= count_reg + 32'd1;
                    if (ptr_wrap)
                    begin
                        ready_reg <= 1'b1;
                    end
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (!root_busy)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        level_reg     <= root_val;
                        detected_reg  <= (root_val > thr_reg);
                        full_reg      <= ready_reg;
                        taken_reg     <= count_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign level          = level_reg;
    assign sound_detected = detected_reg;
    assign window_full    = full_reg;
    assign samples_taken  = taken_reg;

    // Root unit is idle whenever the block takes a new beat.
    a_root_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !root_busy)
        else $error("root unit busy while input is open");

    // A clear beat empties the window state by the next cycle.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_CLEAR) |=>
            (sum_reg == '0 && ptr_reg == '0 && !ready_reg))
        else $error("clear did not reset window state");

    // Level never exceeds the root of the largest mean square.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level <= 16'd32768))
        else $error("level out of range");

    // A pending result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && state_reg == ST_FINISH) |=> (state_reg == ST_FINISH))
        else $error("result loaded over a stalled beat");

endmodule

[hw/rtl/wrsd_store.sv]
module wrsd_store
    import wrsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  store_req_t                 req,
    output logic signed [SAMPLE_W-1:0] rd_data,
    output logic                       rd_valid
);

    logic signed [SAMPLE_W-1:0] mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]    valid_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.addr];
    end

    // Entry not valid reads with rd_valid low; clear drops every valid bit at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[req.addr];
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[hw/rtl/wrsd_sqrt.sv]
module wrsd_sqrt
    import wrsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RAD_W-1:0]  x_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              take;

    // One result bit per cycle, two radicand bits brought down each step.
    always_comb
    begin
        rem_sh = {rem_reg[ROOT_W-1:0], x_reg[RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            x_reg    <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_W - 1);
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

[dv/tb_windowed_rms_sound_detector.sv]
module tb_windowed_rms_sound_detector;
    import wrsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS     = 1950;
    localparam int CYCLE_LIMIT = 600000;   // watchdog limit, above the slowest legal run
    localparam int TAIL_CYCLES = 40;       // longer than the store latency

    // One input beat as queued for the driver.
    typedef struct packed {
        logic                m;
        logic [SAMPLE_W-1:0] s;
    } audio_beat_t;

    // One predicted output beat.
    typedef struct packed {
        logic [ROOT_W-1:0] level;
        logic              detected;
        logic              full;
        logic [31:0]       taken;
    } rms_result_t;

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       cfg_we         = 1'b0;
    logic [15:0]                cfg_wdata      = '0;
    logic                       in_valid       = 1'b0;
    logic                       in_stall;
    logic                       mode           = MODE_STORE;
    logic signed [SAMPLE_W-1:0] sample         = '0;
    logic                       out_valid;
    logic                       out_stall      = 1'b0;
    logic [ROOT_W-1:0]          level;
    logic                       sound_detected;
    logic                       window_full;
    logic [31:0]                samples_taken;

    windowed_rms_sound_detector u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .level          (level),
        .sound_detected (sound_detected),
        .window_full    (window_full),
        .samples_taken  (samples_taken)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Window predictor: a shadow copy of the sample store, the running
    // sum of squares, the wrap flag and the sample count.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] win_mem [WINDOW_DEPTH];
    int                         wr_ptr;
    longint                     sq_sum;
    logic                       win_ready;
    logic [31:0]                n_taken;
    logic [15:0]                det_threshold;

    audio_beat_t sample_beats [$];   // beats waiting for the driver
    rms_result_t level_expect [$];   // predicted results, oldest first

    bit  bursts_on;                  // random gaps and stalls enabled
    int  mismatches;
    int  n_stores, n_clears, n_checked, n_settings, n_full, n_detect;
    int  peak_level;
    int  pushed;

    // floor(sqrt(x)), one result bit per step from the top down
    function automatic logic [ROOT_W-1:0] floor_sqrt(input longint x);
        longint root;
        longint trial;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root[ROOT_W-1:0];
    endfunction

    task automatic advance_window(input logic m, input logic signed [SAMPLE_W-1:0] s);
        longint      old_v;
        longint      new_v;
        rms_result_t r;
        if (m == MODE_CLEAR)
        begin
            // clear keeps the sample count; sample field is don't-care
            foreach (win_mem[i])
                win_mem[i] = '0;
            wr_ptr    = 0;
            sq_sum    = 0;
            win_ready = 1'b0;
            n_clears++;
        end
        else
        begin
            old_v           = win_mem[wr_ptr];
            new_v           = s;
            sq_sum          = sq_sum - old_v * old_v + new_v * new_v;
            win_mem[wr_ptr] = s;
            wr_ptr          = (wr_ptr + 1) % WINDOW_DEPTH;
            n_taken         = n_taken + 32'd1;
            if (wr_ptr == 0)
                win_ready = 1'b1;
            n_stores++;
        end
        r.level    = floor_sqrt(sq_sum / WINDOW_DEPTH);
        r.detected = (r.level > det_threshold);
        r.full     = win_ready;
        r.taken    = n_taken;
        if (int'(r.level) > peak_level)
            peak_level = int'(r.level);
        level_expect.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued beats; a new beat is loaded only once the
    // current one has gone, so a stalled payload never moves.
    // ------------------------------------------------------------------
    int          hold_off;
    audio_beat_t nxt_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode     <= MODE_STORE;
            sample   <= '0;
            hold_off = 0;
        end
        else
        begin
            // predict on acceptance, using the pre-edge payload
            if (in_valid && !in_stall)
                advance_window(mode, sample);
            if (!in_valid || !in_stall)
            begin
                if (hold_off > 0)
                begin
                    hold_off--;
                    in_valid <= 1'b0;
                end
                else if (sample_beats.size() > 0)
                begin
                    nxt_beat = sample_beats.pop_front();
                    in_valid <= 1'b1;
                    mode     <= nxt_beat.m;
                    sample   <= nxt_beat.s;
                    if (bursts_on && $urandom_range(0, 3) == 0)
                        hold_off = $urandom_range(1, 14);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction
    // and drives out_stall in random bursts.
    // ------------------------------------------------------------------
    int          stall_left;
    rms_result_t exp_r;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (level_expect.size() == 0)
                begin
                    $error("result beat with nothing expected: level %0d", level);
                    mismatches++;
                end
                else
                begin
                    exp_r = level_expect.pop_front();
                    n_checked++;
                    if (level !== exp_r.level)
                    begin
                        $error("level: expected %0d, got %0d", exp_r.level, level);
                        mismatches++;
                    end
                    if (sound_detected !== exp_r.detected)
                    begin
                        $error("sound_detected: expected %0b, got %0b",
                               exp_r.detected, sound_detected);
                        mismatches++;
                    end
                    if (window_full !== exp_r.full)
                    begin
                        $error("window_full: expected %0b, got %0b", exp_r.full, window_full);
                        mismatches++;
                    end
                    if (samples_taken !== exp_r.taken)
                    begin
                        $error("samples_taken: expected %0d, got %0d",
                               exp_r.taken, samples_taken);
                        mismatches++;
                    end
                    if (exp_r.full)
                        n_full++;
                    if (exp_r.detected)
                        n_detect++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (bursts_on && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog
    int cycles;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void queue_beat(input logic m, input logic [SAMPLE_W-1:0] s);
        audio_beat_t b;
        b.m = m;
        b.s = s;
        sample_beats.push_back(b);
        pushed++;
    endfunction

    // Block is idle once nothing is queued, on the bus or in flight.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_beats.size() != 0 || in_valid || level_expect.size() != 0);
    endtask

    task automatic write_threshold(input logic [15:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        det_threshold = v;
        n_settings++;
    endtask

    // One stretch of traffic of up to 'budget' beats; returns beats used.
    function automatic int add_segment(input int budget);
        int          len;
        int          kind;
        logic [15:0] v;
        len  = $urandom_range(1, 300);
        kind = $urandom_range(0, 9);
        if (len > budget)
            len = budget;
        case (kind)
            0, 1:       // fresh window, full-scale noise
            begin
                queue_beat(MODE_CLEAR, 16'($urandom));
                for (int i = 1; i < len; i++)
                    queue_beat(MODE_STORE, 16'($urandom));
            end
            2, 3:       // quiet signal, levels near a low threshold
            begin
                for (int i = 0; i < len; i++)
                begin
                    v = 16'($urandom_range(0, 255));
                    queue_beat(MODE_STORE, $urandom_range(0, 1) ? v : -v);
                end
            end
            4:          // constant full-scale tone
            begin
                v = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                for (int i = 0; i < len; i++)
                    queue_beat(MODE_STORE, v);
            end
            5:          // stray clears
            begin
                if (len > 3)
                    len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    queue_beat(MODE_CLEAR, 16'($urandom));
            end
            default:    // noise with an occasional clear mixed in
            begin
                for (int i = 0; i < len; i++)
                    queue_beat($urandom_range(0, 19) == 0 ? MODE_CLEAR : MODE_STORE,
                               16'($urandom));
            end
        endcase
        return len;
    endfunction

    int          phase;
    int          phase_left;
    logic [15:0] thr;

    initial
    begin
        foreach (win_mem[i])
            win_mem[i] = '0;
        wr_ptr        = 0;
        sq_sum        = 0;
        win_ready     = 1'b0;
        n_taken       = '0;
        det_threshold = '0;
        bursts_on     = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, bit patterns, clears with junk in sample
        write_threshold(16'd100);
        queue_beat(MODE_STORE, 16'h7fff);
        queue_beat(MODE_STORE, 16'h8000);
        queue_beat(MODE_STORE, 16'h0000);
        queue_beat(MODE_STORE, 16'hffff);
        queue_beat(MODE_STORE, 16'h0001);
        queue_beat(MODE_STORE, 16'h5555);
        queue_beat(MODE_STORE, 16'haaaa);
        queue_beat(MODE_STORE, 16'h8001);
        queue_beat(MODE_CLEAR, 16'h7fff);
        queue_beat(MODE_CLEAR, 16'h8000);
        queue_beat(MODE_STORE, 16'd1000);
        queue_beat(MODE_STORE, -16'sd1000);
        queue_beat(MODE_STORE, 16'd1700);
        queue_beat(MODE_CLEAR, 16'hffff);
        queue_beat(MODE_STORE, 16'h8000);
        queue_beat(MODE_STORE, 16'h0000);
        queue_beat(MODE_CLEAR, 16'h0000);

        // Random phases, one threshold setting each
        phase = 0;
        while (pushed < N_ITEMS)
        begin
            wait_idle();
            case (phase % 6)
                0: thr = 16'd32767;
                1: thr = 16'd32768;
                2: thr = 16'hffff;
                3: thr = 16'd0;
                4: thr = 16'($urandom);
                default: thr = 16'($urandom_range(0, 3000));
            endcase
            write_threshold(thr);
            // last stretch of the run goes without gaps or stalls
            bursts_on = (pushed + 300 < N_ITEMS) ? ($urandom_range(0, 4) != 0) : 1'b0;

            phase_left = 200 + $urandom_range(0, 100);
            if (phase_left > N_ITEMS - pushed)
                phase_left = N_ITEMS - pushed;
            // Window of all most-negative samples gives level 32768:
            // detected above 32767, not above 32768.
            if (phase < 2)
            begin
                if (phase == 0)
                    queue_beat(MODE_CLEAR, 16'($urandom));
                for (int i = 0; i < WINDOW_DEPTH + 4; i++)
                    queue_beat(MODE_STORE, 16'h8000);
                phase_left = 40;
            end
            while (phase_left > 0)
                phase_left -= add_segment(phase_left);
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d stores, %0d clears, %0d threshold settings.",
                 n_checked, n_stores, n_clears, n_settings);
        $display("Peak level %0d; %0d results with window full, %0d with sound detected.",
                 peak_level, n_full, n_detect);
        if (mismatches == 0 && level_expect.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/wrsd_pkg.sv
hw/rtl/wrsd_store.sv
hw/rtl/wrsd_sqrt.sv
hw/rtl/windowed_rms_sound_detector.sv
dv/tb_windowed_rms_sound_detector.sv
